// ===== rtl/psi_pkg.sv =====
// Package: shared constants and types for the priority stack.
`timescale 1ns / 1ps
package psi_pkg;

  localparam int DEPTH      = 16;
  localparam int ELEM_BITS  = 32;
  localparam int PRIO_BITS  = 8;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef logic [ELEM_BITS-1:0]  elem_t;
  typedef logic [PRIO_BITS-1:0]  prio_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture input beat
    logic commit;  // update store and load result register
  } ctrl_t;

endpackage

// ===== rtl/psi_ctrl.sv =====
// Controller: sequences capture, commit and result handshake.
`timescale 1ns / 1ps
module psi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output psi_pkg::ctrl_t ctrl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_free;
  logic out_valid_next;

  assign in_ready    = (state == S_IDLE);
  assign out_free    = !out_valid || out_ready;
  assign ctrl.load   = in_ready && in_valid;
  assign ctrl.commit = (state == S_EXEC) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (ctrl.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/psi_datapath.sv =====
// Datapath: sorted entry row with parallel compare/shift and result register.
`timescale 1ns / 1ps
module psi_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  psi_pkg::ctrl_t         ctrl,
  input  logic                   command,
  input  logic [psi_pkg::ELEM_BITS-1:0]  elem_value,
  input  logic [psi_pkg::PRIO_BITS-1:0]  elem_priority,
  output logic [psi_pkg::ELEM_BITS-1:0]  top_value,
  output logic [psi_pkg::PRIO_BITS-1:0]  top_priority,
  output logic [psi_pkg::COUNT_BITS-1:0] entry_count,
  output logic                   is_empty,
  output logic                   error_flag
);

  logic           cmd_q;
  psi_pkg::elem_t val_q;
  psi_pkg::prio_t pri_q;

  psi_pkg::elem_t  vals [psi_pkg::DEPTH];
  psi_pkg::prio_t  pris [psi_pkg::DEPTH];
  psi_pkg::count_t count;

  psi_pkg::elem_t  vals_next [psi_pkg::DEPTH];
  psi_pkg::prio_t  pris_next [psi_pkg::DEPTH];
  psi_pkg::count_t count_next;
  logic [psi_pkg::DEPTH-1:0] gt;
  logic err;

  always_comb begin
    for (int i = 0; i < psi_pkg::DEPTH; i++) begin
      gt[i] = (count > psi_pkg::COUNT_BITS'(i)) && (pris[i] > pri_q);
    end
  end

  always_comb begin
    err        = 1'b0;
    count_next = count;
    for (int i = 0; i < psi_pkg::DEPTH; i++) begin
      vals_next[i] = vals[i];
      pris_next[i] = pris[i];
    end
    if (cmd_q == psi_pkg::CMD_PUSH) begin
      if (count == psi_pkg::COUNT_BITS'(psi_pkg::DEPTH)) begin
        err = 1'b1;
      end else begin
        count_next = count + 1'b1;
        if (!gt[0]) begin
          vals_next[0] = val_q;
          pris_next[0] = pri_q;
        end
        for (int i = 1; i < psi_pkg::DEPTH; i++) begin
          if (!gt[i]) begin
            if (gt[i-1]) begin
              vals_next[i] = val_q;
              pris_next[i] = pri_q;
            end else begin
              vals_next[i] = vals[i-1];
              pris_next[i] = pris[i-1];
            end
          end
        end
      end
    end else begin
      if (count == '0) begin
        err = 1'b1;
      end else begin
        count_next = count - 1'b1;
        for (int i = 0; i < psi_pkg::DEPTH - 1; i++) begin
          vals_next[i] = vals[i+1];
          pris_next[i] = pris[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q <= command;
      val_q <= elem_value;
      pri_q <= elem_priority;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      for (int i = 0; i < psi_pkg::DEPTH; i++) begin
        vals[i] <= vals_next[i];
        pris[i] <= pris_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      top_value    <= (count_next == '0) ? '0 : vals_next[0];
      top_priority <= (count_next == '0) ? '0 : pris_next[0];
      entry_count  <= count_next;
      is_empty     <= (count_next == '0);
      error_flag   <= err;
    end
  end

endmodule

// ===== rtl/priority_stack_sorted_insert.sv =====
// Top level: bounded priority stack with sorted insert.
`timescale 1ns / 1ps
// Each input beat is a push (command 0) or a pop (command 1) and yields one
// result beat describing the store afterward: front element and priority (zero
// when empty), entry count, empty flag and an error flag for a pop on empty or
// a push when full (store unchanged). Equal priorities leave newest first.
// From input accept to result, the beat is first captured; then, once the output
// is free, all 16 entries compare against the new priority and shift in parallel.
// A new beat is taken only after the previous one has been committed; the input
// is accepted even while a finished result waits to be taken.
module priority_stack_sorted_insert (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   command,
  input  logic [psi_pkg::ELEM_BITS-1:0]  elem_value,
  input  logic [psi_pkg::PRIO_BITS-1:0]  elem_priority,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [psi_pkg::ELEM_BITS-1:0]  top_value,
  output logic [psi_pkg::PRIO_BITS-1:0]  top_priority,
  output logic [psi_pkg::COUNT_BITS-1:0] entry_count,
  output logic                   is_empty,
  output logic                   error_flag
);

  psi_pkg::ctrl_t ctrl;

  psi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  psi_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .command       (command),
    .elem_value    (elem_value),
    .elem_priority (elem_priority),
    .top_value     (top_value),
    .top_priority  (top_priority),
    .entry_count   (entry_count),
    .is_empty      (is_empty),
    .error_flag    (error_flag)
  );

endmodule

// ===== rtl/psi_checker.sv =====
// Checker: port-level properties of the priority stack, bound to the top level.
`timescale 1ns / 1ps
module psi_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [psi_pkg::ELEM_BITS-1:0]  top_value,
  input logic [psi_pkg::PRIO_BITS-1:0]  top_priority,
  input logic [psi_pkg::COUNT_BITS-1:0] entry_count,
  input logic                   is_empty,
  input logic                   error_flag
);

  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(top_value) &&
      $stable(entry_count) && $stable(error_flag))
    else $error("stalled result beat changed");

  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> (top_value == '0) && (top_priority == '0))
    else $error("empty store shows nonzero front");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= psi_pkg::COUNT_BITS'(psi_pkg::DEPTH))
    else $error("entry_count beyond depth");

endmodule

bind priority_stack_sorted_insert psi_checker u_psi_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .top_value    (top_value),
  .top_priority (top_priority),
  .entry_count  (entry_count),
  .is_empty     (is_empty),
  .error_flag   (error_flag)
);

// ===== sim/tb_priority_stack_sorted_insert.sv =====
// Testbench for the priority stack: directed table plus random push/pop traffic,
// every result beat checked against typed table values or a shadow sorted stack.
`timescale 1ns / 1ps
module tb_priority_stack_sorted_insert;

  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 1050;

  typedef struct packed {
    psi_pkg::elem_t  value;
    psi_pkg::prio_t  prio;
    psi_pkg::count_t count;
    logic            empty;
    logic            err;
  } stack_status_t;

  typedef struct {
    logic           cmd;
    psi_pkg::elem_t val;
    psi_pkg::prio_t pri;
    bit             typed;
    stack_status_t  exp;
  } stim_row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            command = psi_pkg::CMD_PUSH;
  psi_pkg::elem_t  elem_value = '0;
  psi_pkg::prio_t  elem_priority = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  psi_pkg::elem_t  top_value;
  psi_pkg::prio_t  top_priority;
  psi_pkg::count_t entry_count;
  logic            is_empty;
  logic            error_flag;

  // shadow store, front at index 0
  psi_pkg::elem_t shadow_val [psi_pkg::DEPTH];
  psi_pkg::prio_t shadow_pri [psi_pkg::DEPTH];
  int             shadow_cnt = 0;

  stack_status_t pending_status[$];
  stim_row_t     stim_rows[$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  bit            quiet_phase = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  priority_stack_sorted_insert i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .elem_value    (elem_value),
    .elem_priority (elem_priority),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .top_value     (top_value),
    .top_priority  (top_priority),
    .entry_count   (entry_count),
    .is_empty      (is_empty),
    .error_flag    (error_flag)
  );

  function automatic stack_status_t stack_apply(logic cmd, psi_pkg::elem_t val,
                                                psi_pkg::prio_t pri);
    stack_status_t s;
    int pos;
    int i;
    s.err = 1'b0;
    if (cmd == psi_pkg::CMD_PUSH) begin
      if (shadow_cnt >= psi_pkg::DEPTH) begin
        s.err = 1'b1;
      end else begin
        pos = 0;
        while (pos < shadow_cnt && shadow_pri[pos] > pri) pos++;
        for (i = shadow_cnt; i > pos; i--) begin
          shadow_val[i] = shadow_val[i-1];
          shadow_pri[i] = shadow_pri[i-1];
        end
        shadow_val[pos] = val;
        shadow_pri[pos] = pri;
        shadow_cnt++;
      end
    end else begin
      if (shadow_cnt == 0) begin
        s.err = 1'b1;
      end else begin
        for (i = 0; i + 1 < shadow_cnt; i++) begin
          shadow_val[i] = shadow_val[i+1];
          shadow_pri[i] = shadow_pri[i+1];
        end
        shadow_cnt--;
      end
    end
    s.value = (shadow_cnt > 0) ? shadow_val[0] : '0;
    s.prio  = (shadow_cnt > 0) ? shadow_pri[0] : '0;
    s.count = psi_pkg::count_t'(shadow_cnt);
    s.empty = (shadow_cnt == 0);
    return s;
  endfunction

  function automatic stack_status_t status(psi_pkg::elem_t v, psi_pkg::prio_t p, int c,
                                           logic e, logic r);
    stack_status_t s;
    s.value = v;
    s.prio  = p;
    s.count = psi_pkg::count_t'(c);
    s.empty = e;
    s.err   = r;
    return s;
  endfunction

  function automatic void add_row(logic cmd, psi_pkg::elem_t val, psi_pkg::prio_t pri,
                                  bit typed, stack_status_t exp);
    stim_row_t r;
    r.cmd   = cmd;
    r.val   = val;
    r.pri   = pri;
    r.typed = typed;
    r.exp   = exp;
    stim_rows.push_back(r);
  endfunction

  task automatic send_beat(stim_row_t r);
    int gap;
    stack_status_t s;
    gap = quiet_phase ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= r.cmd;
    elem_value    <= r.val;
    elem_priority <= r.pri;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    s = stack_apply(r.cmd, r.val, r.pri);
    pending_status.push_back(r.typed ? r.exp : s);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic check_beat();
    stack_status_t exp;
    bit bad;
    if (pending_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat: top %h/%h count %0d empty %b err %b",
                 top_value, top_priority, entry_count, is_empty, error_flag);
    end else begin
      exp = pending_status.pop_front();
      bad = (top_value !== exp.value) || (top_priority !== exp.prio) ||
            (entry_count !== exp.count) || (is_empty !== exp.empty) ||
            (error_flag !== exp.err);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h/%h %0d %b %b, got %h/%h %0d %b %b",
                   exp.value, exp.prio, exp.count, exp.empty, exp.err,
                   top_value, top_priority, entry_count, is_empty, error_flag);
      end
    end
  endtask

  // result side
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_beat();
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    stim_row_t r;
    int push_pct;
    int prio_mode;
    int n;
    int k;

    add_row(psi_pkg::CMD_POP, '0, '0, 1'b1, status('0, '0, 0, 1'b1, 1'b1));
    add_row(psi_pkg::CMD_PUSH, 32'hFFFF_FFFF, 8'hFF, 1'b1,
            status(32'hFFFF_FFFF, 8'hFF, 1, 1'b0, 1'b0));
    add_row(psi_pkg::CMD_PUSH, 32'h0, 8'h00, 1'b1,
            status(32'hFFFF_FFFF, 8'hFF, 2, 1'b0, 1'b0));
    // equal priority goes ahead
    add_row(psi_pkg::CMD_PUSH, 32'h1, 8'hFF, 1'b1,
            status(32'h1, 8'hFF, 3, 1'b0, 1'b0));
    add_row(psi_pkg::CMD_POP, '0, '0, 1'b1,
            status(32'hFFFF_FFFF, 8'hFF, 2, 1'b0, 1'b0));
    add_row(psi_pkg::CMD_POP, '0, '0, 1'b1, status('0, '0, 1, 1'b0, 1'b0));
    add_row(psi_pkg::CMD_POP, '0, '0, 1'b1, status('0, '0, 0, 1'b1, 1'b0));
    add_row(psi_pkg::CMD_POP, 32'hFFFF_FFFF, 8'hFF, 1'b1,
            status('0, '0, 0, 1'b1, 1'b1));
    for (k = 0; k < psi_pkg::DEPTH; k++)
      add_row(psi_pkg::CMD_PUSH, 32'hA5A5_0000 + k, psi_pkg::prio_t'((k * 37) % 7),
              1'b0, '0);
    // push into a full store
    add_row(psi_pkg::CMD_PUSH, 32'h5A5A_5A5A, 8'hFF, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[j]) send_beat(stim_rows[j]);
    hold_until_drained();

    push_pct  = 50;
    prio_mode = 0;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
        prio_mode   = $urandom_range(0, 2);
        quiet_phase = ($urandom_range(0, 3) == 0);
      end
      if (n == RAND_ITEMS / 2) hold_until_drained();
      r.cmd = ($urandom_range(1, 100) <= push_pct) ? psi_pkg::CMD_PUSH : psi_pkg::CMD_POP;
      r.val = $urandom;
      case (prio_mode)
        0: r.pri = psi_pkg::prio_t'($urandom_range(0, 3));
        1: r.pri = psi_pkg::prio_t'($urandom_range(0, 255));
        default: r.pri = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      r.typed = 1'b0;
      r.exp   = '0;
      send_beat(r);
    end

    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/psi_pkg.sv
rtl/psi_ctrl.sv
rtl/psi_datapath.sv
rtl/priority_stack_sorted_insert.sv
rtl/psi_checker.sv
sim/tb_priority_stack_sorted_insert.sv
